FILE: src/rmj_pkg.sv
// Shared types and helpers for the radar measurement Jacobian pipeline.
// No dependencies; imported by the front end, back end and top level.
`default_nettype none

package rmj_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned SQ_W   = 64;
	localparam int unsigned CFG_W  = 16;

	localparam logic [63:0] POS_LIM = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] NEG_LIM = 64'h0000_0000_8000_0000;

	typedef struct packed {
		logic [WORD_W-1:0] apx;
		logic [WORD_W-1:0] apy;
		logic              sx;
		logic              sy;
		logic [SQ_W-1:0]   s;
		logic [SQ_W-1:0]   acm;
		logic              cneg;
		logic              sing;
	} fr_t;

	typedef struct packed {
		logic [WORD_W-1:0] apx;
		logic [WORD_W-1:0] apy;
		logic              sx;
		logic              sy;
		logic              cneg;
		logic              sing;
	} sa_t;

	typedef struct packed {
		logic [WORD_W-1:0] qpx;
		logic [WORD_W-1:0] qpy;
		logic              sx;
		logic              sy;
		logic              cneg;
		logic              sing;
	} sb_t;

	function automatic logic [WORD_W-1:0] sat_out(input logic neg, input logic [63:0] mag);
		logic [63:0] m;
		if (neg) begin
			m = (mag > NEG_LIM) ? NEG_LIM : mag;
			sat_out = ~m[WORD_W-1:0] + 32'd1;
		end else begin
			m = (mag > POS_LIM) ? POS_LIM : mag;
			sat_out = m[WORD_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

FILE: src/rmj_front.sv
// Front end: magnitudes, squared range, cross term and singular test.
// Five register stages; uses rmj_pkg.
`default_nettype none

module rmj_front #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      en,
	input  wire logic                      in_valid,
	input  wire logic [rmj_pkg::WORD_W-1:0] pos_x,
	input  wire logic [rmj_pkg::WORD_W-1:0] pos_y,
	input  wire logic [rmj_pkg::WORD_W-1:0] vel_x,
	input  wire logic [rmj_pkg::WORD_W-1:0] vel_y,
	input  wire logic [rmj_pkg::CFG_W-1:0]  min_norm_sq,
	output logic                           out_valid,
	output rmj_pkg::fr_t                   out_fr
);
	import rmj_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [31:0] px_s1, py_s1, vx_s1, vy_s1;
	logic signed [31:0] px_s2, py_s2, vx_s2, vy_s2;
	logic [31:0] apx_s2, apy_s2, apx_s3, apy_s3, apx_s4, apy_s4;
	logic sx_s2, sy_s2, sx_s3, sy_s3, sx_s4, sy_s4;
	logic [63:0] sqx_s2, sqy_s2, s_s3, s_s4;
	logic signed [63:0] pvx_s3, pvy_s3;
	logic signed [64:0] c_s4;
	logic sing_s4;
	fr_t fr_s5;

	logic signed [63:0] sqx, sqy, pvx, pvy;
	logic signed [64:0] c;
	logic [63:0] thr;

	assign sqx = px_s1 * px_s1;
	assign sqy = py_s1 * py_s1;
	assign pvx = vx_s2 * py_s2;
	assign pvy = vy_s2 * px_s2;
	assign c   = pvx_s3 - pvy_s3;
	assign thr = 64'({min_norm_sq, {FRAC_BITS{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= pos_x;
			py_s1 <= pos_y;
			vx_s1 <= vel_x;
			vy_s1 <= vel_y;

			px_s2  <= px_s1;
			py_s2  <= py_s1;
			vx_s2  <= vx_s1;
			vy_s2  <= vy_s1;
			sqx_s2 <= sqx;
			sqy_s2 <= sqy;
			apx_s2 <= px_s1[31] ? (~px_s1 + 32'd1) : px_s1;
			apy_s2 <= py_s1[31] ? (~py_s1 + 32'd1) : py_s1;
			sx_s2  <= px_s1[31];
			sy_s2  <= py_s1[31];

			s_s3   <= sqx_s2 + sqy_s2;
			pvx_s3 <= pvx;
			pvy_s3 <= pvy;
			apx_s3 <= apx_s2;
			apy_s3 <= apy_s2;
			sx_s3  <= sx_s2;
			sy_s3  <= sy_s2;

			c_s4    <= c;
			sing_s4 <= (s_s3 == 64'd0) || (s_s3 < thr);
			s_s4    <= s_s3;
			apx_s4  <= apx_s3;
			apy_s4  <= apy_s3;
			sx_s4   <= sx_s3;
			sy_s4   <= sy_s3;

			fr_s5.apx  <= apx_s4;
			fr_s5.apy  <= apy_s4;
			fr_s5.sx   <= sx_s4;
			fr_s5.sy   <= sy_s4;
			fr_s5.s    <= s_s4;
			fr_s5.acm  <= c_s4[64] ? (~c_s4[63:0] + 64'd1) : c_s4[63:0];
			fr_s5.cneg <= c_s4[64];
			fr_s5.sing <= sing_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_fr    = fr_s5;

endmodule

`default_nettype wire

FILE: src/rmj_sqrt.sv
// Pipelined integer square root of a 64-bit value, two radicand bits a stage.
// Self-contained; sideband travels alongside each beat.
`default_nettype none

module rmj_sqrt #(
	parameter int LAT = 33,
	parameter int SBW = 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire logic [63:0]    in_rad,
	input  wire logic [SBW-1:0] in_sb,
	output logic                out_valid,
	output logic [31:0]         out_root,
	output logic [SBW-1:0]      out_sb
);
	localparam int STEPS = 32;

	logic           vld_s  [LAT];
	logic [33:0]    rem_s  [LAT];
	logic [31:0]    root_s [LAT];
	logic [63:0]    rad_s  [LAT];
	logic [SBW-1:0] sb_s   [LAT];

	for (genvar k = 0; k < LAT; k++) begin : g_st
		logic           p_v, n_v;
		logic [33:0]    p_rem, n_rem;
		logic [31:0]    p_root, n_root;
		logic [63:0]    p_rad, n_rad;
		logic [SBW-1:0] p_sb;

		if (k == 0) begin : g_in
			assign p_v    = in_valid;
			assign p_rem  = '0;
			assign p_root = '0;
			assign p_rad  = in_rad;
			assign p_sb   = in_sb;
		end else begin : g_prev
			assign p_v    = vld_s[k-1];
			assign p_rem  = rem_s[k-1];
			assign p_root = root_s[k-1];
			assign p_rad  = rad_s[k-1];
			assign p_sb   = sb_s[k-1];
		end

		assign n_v = p_v;

		if (k < STEPS) begin : g_step
			logic [35:0] tmp, trial, diff;
			logic        ge;
			assign tmp    = {p_rem, p_rad[63:62]};
			assign trial  = {2'b00, p_root, 2'b01};
			assign diff   = tmp - trial;
			assign ge     = tmp >= trial;
			assign n_rem  = ge ? diff[33:0] : tmp[33:0];
			assign n_root = {p_root[30:0], ge};
			assign n_rad  = {p_rad[61:0], 2'b00};
		end else begin : g_pass
			assign n_rem  = p_rem;
			assign n_root = p_root;
			assign n_rad  = p_rad;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= n_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= n_rem;
				root_s[k] <= n_root;
				rad_s[k]  <= n_rad;
				sb_s[k]   <= p_sb;
			end
		end
	end

	assign out_valid = vld_s[LAT-1];
	assign out_root  = root_s[LAT-1];
	assign out_sb    = sb_s[LAT-1];

endmodule

`default_nettype wire

FILE: src/rmj_div.sv
// Pipelined restoring divider, one quotient bit a stage, all-ones on overflow.
// Self-contained; sideband travels alongside each beat.
`default_nettype none

module rmj_div #(
	parameter int NW  = 48,
	parameter int DW  = 32,
	parameter int QW  = 32,
	parameter int LAT = 33,
	parameter int SBW = 1
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           in_valid,
	input  wire logic [NW-1:0]  in_num,
	input  wire logic [DW-1:0]  in_den,
	input  wire logic [SBW-1:0] in_sb,
	output logic                out_valid,
	output logic [QW-1:0]       out_quo,
	output logic [SBW-1:0]      out_sb
);
	logic           vld_s [LAT];
	logic [DW-1:0]  rem_s [LAT];
	logic [DW-1:0]  den_s [LAT];
	logic [QW-1:0]  nq_s  [LAT];
	logic           ovf_s [LAT];
	logic [SBW-1:0] sb_s  [LAT];

	for (genvar k = 0; k < LAT; k++) begin : g_st
		logic           n_v, n_ovf;
		logic [DW-1:0]  n_rem, n_den;
		logic [QW-1:0]  n_nq;
		logic [SBW-1:0] n_sb;

		if (k == 0) begin : g_pre
			logic [DW-1:0] hi;
			assign hi    = DW'(in_num[NW-1:QW]);
			assign n_v   = in_valid;
			assign n_ovf = hi >= in_den;
			assign n_rem = hi;
			assign n_den = in_den;
			assign n_nq  = in_num[QW-1:0];
			assign n_sb  = in_sb;
		end else if (k <= QW) begin : g_step
			logic [DW:0] tmp, diff;
			logic        ge;
			assign tmp   = {rem_s[k-1], nq_s[k-1][QW-1]};
			assign diff  = tmp - {1'b0, den_s[k-1]};
			assign ge    = tmp >= {1'b0, den_s[k-1]};
			assign n_v   = vld_s[k-1];
			assign n_ovf = ovf_s[k-1];
			assign n_rem = ge ? diff[DW-1:0] : tmp[DW-1:0];
			assign n_den = den_s[k-1];
			assign n_nq  = {nq_s[k-1][QW-2:0], ge};
			assign n_sb  = sb_s[k-1];
		end else begin : g_pass
			assign n_v   = vld_s[k-1];
			assign n_ovf = ovf_s[k-1];
			assign n_rem = rem_s[k-1];
			assign n_den = den_s[k-1];
			assign n_nq  = nq_s[k-1];
			assign n_sb  = sb_s[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= n_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ovf_s[k] <= n_ovf;
				rem_s[k] <= n_rem;
				den_s[k] <= n_den;
				nq_s[k]  <= n_nq;
				sb_s[k]  <= n_sb;
			end
		end
	end

	assign out_valid = vld_s[LAT-1];
	assign out_quo   = ovf_s[LAT-1] ? {QW{1'b1}} : nq_s[LAT-1];
	assign out_sb    = sb_s[LAT-1];

endmodule

`default_nettype wire

FILE: src/rmj_back.sv
// Back end: clamps, range-rate products, saturation and the output register.
// Four register stages; uses rmj_pkg.
`default_nettype none

module rmj_back #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [rmj_pkg::WORD_W-1:0]   wxq,
	input  wire logic [rmj_pkg::WORD_W-1:0]   wyq,
	input  wire logic [32+FRAC_BITS-1:0]      kq,
	input  wire rmj_pkg::sb_t                 sb,
	output logic                             out_valid,
	output logic [rmj_pkg::WORD_W-1:0]       drange_dpx,
	output logic [rmj_pkg::WORD_W-1:0]       drange_dpy,
	output logic [rmj_pkg::WORD_W-1:0]       dbearing_dpx,
	output logic [rmj_pkg::WORD_W-1:0]       dbearing_dpy,
	output logic [rmj_pkg::WORD_W-1:0]       drate_dpx,
	output logic [rmj_pkg::WORD_W-1:0]       drate_dpy,
	output logic                             singular
);
	import rmj_pkg::*;

	localparam int KW = 32 + FRAC_BITS;
	localparam int PW = 64 + FRAC_BITS;
	localparam logic [KW-1:0] KCAP = KW'(1) << (31 + FRAC_BITS);
	localparam logic [31:0]   WCAP = 32'h8000_0000;

	logic v_s1, v_s2, v_s3, v_s4;
	logic [31:0] wx_s1, wy_s1;
	logic [KW-1:0] k_s1;
	logic [31:0] drx_s1, dry_s1, dbx_s1, dby_s1;
	logic [31:0] drx_s2, dry_s2, dbx_s2, dby_s2;
	logic [31:0] drx_s3, dry_s3, dbx_s3, dby_s3;
	logic nrx_s1, nry_s1, nrx_s2, nry_s2, nrx_s3, nry_s3;
	logic sing_s1, sing_s2, sing_s3;
	logic [63:0] plx_s2, ply_s2;
	logic [KW-1:0] phx_s2, phy_s2;
	logic [63:0] mx_s3, my_s3;
	logic [31:0] drx_s4, dry_s4, dbx_s4, dby_s4, rtx_s4, rty_s4;
	logic sing_s4;

	logic [PW-1:0] sumx, sumy;

	assign sumx = PW'(plx_s2) + {phx_s2, 32'd0};
	assign sumy = PW'(ply_s2) + {phy_s2, 32'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1   <= (wxq > WCAP) ? WCAP : wxq;
			wy_s1   <= (wyq > WCAP) ? WCAP : wyq;
			k_s1    <= (kq > KCAP) ? KCAP : kq;
			drx_s1  <= sat_out(sb.sx, 64'(wxq));
			dry_s1  <= sat_out(sb.sy, 64'(wyq));
			dbx_s1  <= sat_out(!sb.sy, 64'(sb.qpy));
			dby_s1  <= sat_out(sb.sx, 64'(sb.qpx));
			nrx_s1  <= sb.sy != sb.cneg;
			nry_s1  <= sb.sx == sb.cneg;
			sing_s1 <= sb.sing;

			plx_s2  <= 64'(wx_s1) * 64'(k_s1[31:0]);
			ply_s2  <= 64'(wy_s1) * 64'(k_s1[31:0]);
			phx_s2  <= KW'(wx_s1) * KW'(k_s1[KW-1:32]);
			phy_s2  <= KW'(wy_s1) * KW'(k_s1[KW-1:32]);
			drx_s2  <= drx_s1;
			dry_s2  <= dry_s1;
			dbx_s2  <= dbx_s1;
			dby_s2  <= dby_s1;
			nrx_s2  <= nrx_s1;
			nry_s2  <= nry_s1;
			sing_s2 <= sing_s1;

			mx_s3   <= sumx[PW-1:FRAC_BITS];
			my_s3   <= sumy[PW-1:FRAC_BITS];
			drx_s3  <= drx_s2;
			dry_s3  <= dry_s2;
			dbx_s3  <= dbx_s2;
			dby_s3  <= dby_s2;
			nrx_s3  <= nrx_s2;
			nry_s3  <= nry_s2;
			sing_s3 <= sing_s2;

			drx_s4  <= sing_s3 ? '0 : drx_s3;
			dry_s4  <= sing_s3 ? '0 : dry_s3;
			dbx_s4  <= sing_s3 ? '0 : dbx_s3;
			dby_s4  <= sing_s3 ? '0 : dby_s3;
			rtx_s4  <= sing_s3 ? '0 : sat_out(nrx_s3, my_s3);
			rty_s4  <= sing_s3 ? '0 : sat_out(nry_s3, mx_s3);
			sing_s4 <= sing_s3;
		end
	end

	assign out_valid    = v_s4;
	assign drange_dpx   = drx_s4;
	assign drange_dpy   = dry_s4;
	assign dbearing_dpx = dbx_s4;
	assign dbearing_dpy = dby_s4;
	assign drate_dpx    = rtx_s4;
	assign drate_dpy    = rty_s4;
	assign singular     = sing_s4;

endmodule

`default_nettype wire

FILE: src/radar_measurement_jacobian.sv
// Top level of the radar measurement Jacobian pipeline.
// Instantiates rmj_front, rmj_sqrt, rmj_div and rmj_back; uses rmj_pkg.
//
// Accepts one state beat per clock unless stalled and returns one Jacobian beat per state,
// in order, with a depth that does not depend on FRAC_BITS: five front stages (squares,
// cross term, threshold test), 33 stages for the 32-step square root alongside the bearing
// dividers, 33 stages for the 32-step range dividers, and four back stages (products,
// saturation, output register). The divider for the range-rate scale runs one step per
// quotient bit across both middle sections. Holding m_tready low while m_tvalid is high
// freezes the whole pipeline and s_tready with it. min_norm_sq resets to 7; the user
// writes it with cfg_we only while no beat is in flight; the block does not enforce this.
`default_nettype none

module radar_measurement_jacobian #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_we,
	input  wire logic [15:0]  cfg_wdata,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// pos_x, pos_y, vel_x, vel_y
	input  wire logic [127:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// drange_dpx, drange_dpy, dbearing_dpx, dbearing_dpy, drate_dpx, drate_dpy
	output logic [191:0]      m_tdata,
	// singular
	output logic              m_tuser
);
	import rmj_pkg::*;

	localparam int PA   = 33;
	localparam int KW   = 32 + FRAC_BITS;
	localparam int SAW  = $bits(sa_t);
	localparam int SBTW = $bits(sb_t);

	logic [CFG_W-1:0] min_norm_sq_q;
	logic en;

	logic fr_valid;
	fr_t  fr;

	logic sq_valid;
	logic [31:0] root;
	logic [SAW-1:0] sq_sb;
	sa_t sa_o;

	logic dbx_valid, dby_valid, k_valid, wx_valid, wy_valid;
	logic [31:0] qpx, qpy, wxq, wyq;
	logic [KW-1:0] kq;
	logic [0:0] dbx_sb, dby_sb, k_sb, wy_sb;
	sb_t sb_i, sb_o;
	logic [SBTW-1:0] wx_sb;

	logic [31:0] drx, dry, dbx, dby, rtx, rty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_norm_sq_q <= 16'd7;
		end else if (cfg_we) begin
			min_norm_sq_q <= cfg_wdata;
		end
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	rmj_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(s_tvalid),
		.pos_x(s_tdata[31:0]), .pos_y(s_tdata[63:32]),
		.vel_x(s_tdata[95:64]), .vel_y(s_tdata[127:96]),
		.min_norm_sq(min_norm_sq_q),
		.out_valid(fr_valid), .out_fr(fr)
	);

	rmj_sqrt #(.LAT(PA), .SBW(SAW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(fr_valid),
		.in_rad(fr.s),
		.in_sb({fr.apx, fr.apy, fr.sx, fr.sy, fr.cneg, fr.sing}),
		.out_valid(sq_valid), .out_root(root), .out_sb(sq_sb)
	);

	assign sa_o = sa_t'(sq_sb);

	rmj_div #(.NW(32 + 2*FRAC_BITS), .DW(64), .QW(32), .LAT(PA), .SBW(1)) u_div_bx (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(fr_valid),
		.in_num({fr.apx, {(2*FRAC_BITS){1'b0}}}), .in_den(fr.s), .in_sb(fr.sing),
		.out_valid(dbx_valid), .out_quo(qpx), .out_sb(dbx_sb)
	);

	rmj_div #(.NW(32 + 2*FRAC_BITS), .DW(64), .QW(32), .LAT(PA), .SBW(1)) u_div_by (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(fr_valid),
		.in_num({fr.apy, {(2*FRAC_BITS){1'b0}}}), .in_den(fr.s), .in_sb(fr.sing),
		.out_valid(dby_valid), .out_quo(qpy), .out_sb(dby_sb)
	);

	rmj_div #(.NW(64 + FRAC_BITS), .DW(64), .QW(KW), .LAT(2*PA), .SBW(1)) u_div_k (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(fr_valid),
		.in_num({fr.acm, {FRAC_BITS{1'b0}}}), .in_den(fr.s), .in_sb(fr.sing),
		.out_valid(k_valid), .out_quo(kq), .out_sb(k_sb)
	);

	assign sb_i.qpx  = qpx;
	assign sb_i.qpy  = qpy;
	assign sb_i.sx   = sa_o.sx;
	assign sb_i.sy   = sa_o.sy;
	assign sb_i.cneg = sa_o.cneg;
	assign sb_i.sing = sa_o.sing;

	rmj_div #(.NW(32 + FRAC_BITS), .DW(32), .QW(32), .LAT(PA), .SBW(SBTW)) u_div_rx (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(sq_valid),
		.in_num({sa_o.apx, {FRAC_BITS{1'b0}}}), .in_den(root), .in_sb(sb_i),
		.out_valid(wx_valid), .out_quo(wxq), .out_sb(wx_sb)
	);

	rmj_div #(.NW(32 + FRAC_BITS), .DW(32), .QW(32), .LAT(PA), .SBW(1)) u_div_ry (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(sq_valid),
		.in_num({sa_o.apy, {FRAC_BITS{1'b0}}}), .in_den(root), .in_sb(sa_o.sing),
		.out_valid(wy_valid), .out_quo(wyq), .out_sb(wy_sb)
	);

	assign sb_o = sb_t'(wx_sb);

	rmj_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .en(en), .in_valid(wx_valid),
		.wxq(wxq), .wyq(wyq), .kq(kq), .sb(sb_o),
		.out_valid(m_tvalid),
		.drange_dpx(drx), .drange_dpy(dry),
		.dbearing_dpx(dbx), .dbearing_dpy(dby),
		.drate_dpx(rtx), .drate_dpy(rty),
		.singular(m_tuser)
	);

	assign m_tdata = {rty, rtx, dby, dbx, dry, drx};

	a_phase_a_align: assert property (@(posedge clk) disable iff (!arst_n)
		(dbx_valid == sq_valid) && (dby_valid == sq_valid))
		else $error("bearing dividers out of step with square root");

	a_phase_b_align: assert property (@(posedge clk) disable iff (!arst_n)
		(k_valid == wx_valid) && (wy_valid == wx_valid))
		else $error("range-rate scale out of step with range dividers");

	a_sing_a: assert property (@(posedge clk) disable iff (!arst_n)
		sq_valid |-> (dbx_sb[0] == sa_o.sing) && (dby_sb[0] == sa_o.sing))
		else $error("singular flag mismatch after square root");

	a_sing_b: assert property (@(posedge clk) disable iff (!arst_n)
		wx_valid |-> (k_sb[0] == sb_o.sing) && (wy_sb[0] == sb_o.sing))
		else $error("singular flag mismatch after range dividers");

	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("singular beat carries nonzero entries");

endmodule

`default_nettype wire
